>>> rtl/dnsle_pkg.sv
// Package for the DNS name label encoder: constants and the structs passed between its parts.
package dnsle_pkg;

    localparam int MAX_LABEL_DEF = 63;
    localparam int CHAR_W        = 8;
    localparam int CNT_W         = 6;

    localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

    // label ready for the back end
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } cmd_t;

    // label store write from the front end
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [CNT_W-1:0]  idx;
        logic [CHAR_W-1:0] data;
    } wr_req_t;

    // bank handed back by the back end
    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

endpackage

>>> rtl/dnsle_front.sv
// Front end: takes characters, fills the open label bank, queues finished labels.
module dnsle_front
    import dnsle_pkg::*;
#(
    parameter int MAX_LABEL = MAX_LABEL_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_last,
    input  logic              fifo_full,
    output logic              push,
    output cmd_t              push_cmd,
    output wr_req_t           wr,
    input  rel_t              rel
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;

    logic             accept;
    logic             is_dot;
    logic             has_room;
    logic [CNT_W-1:0] count_add;
    logic             ovf_add;

    assign in_ready = !busy_reg[bank_reg] && !fifo_full;
    assign accept   = in_valid && in_ready;
    assign is_dot   = (in_char == DOT_CHAR);
    assign has_room = (count_reg < CNT_W'(MAX_LABEL));

    // label state after taking a plain character
    assign count_add = has_room ? count_reg + CNT_W'(1) : count_reg;
    assign ovf_add   = ovf_reg || !has_room;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        push       = 1'b0;
        push_cmd   = '{bank: bank_reg, count: count_reg, ovf: ovf_reg};
        wr         = '{en: 1'b0, bank: bank_reg, idx: count_reg, data: in_char};

        if (rel.en)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            if (is_dot)
            begin
                push = 1'b1;
            end
            else
            begin
                wr.en    = has_room;
                push     = in_last;
                push_cmd = '{bank: bank_reg, count: count_add, ovf: ovf_add};
                count_next = count_add;
                ovf_next   = ovf_add;
            end

            if (push)
            begin
                busy_next[bank_reg] = 1'b1;
                bank_next  = !bank_reg;
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

>>> rtl/dnsle_cmd_fifo.sv
// Two-entry queue of finished labels between front and back end.
module dnsle_cmd_fifo
    import dnsle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t       slot0_reg, slot0_next;
    cmd_t       slot1_reg, slot1_next;
    logic [1:0] fill_reg, fill_next;

    assign head  = slot0_reg;
    assign empty = (fill_reg == 2'd0);
    assign full  = (fill_reg == 2'd2);

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        fill_next  = fill_reg;
        case ({push, pop})
            2'b10:
            begin
                if (fill_reg == 2'd0)
                begin
                    slot0_next = push_cmd;
                end
                else
                begin
                    slot1_next = push_cmd;
                end
                fill_next = fill_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                fill_next  = fill_reg - 2'd1;
            end
            2'b11:
            begin
                // pop only happens with one or two entries held
                if (fill_reg == 2'd1)
                begin
                    slot0_next = push_cmd;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = push_cmd;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

>>> rtl/dnsle_back.sv
// Back end: label store banks and the sequencer that sends length and character words.
module dnsle_back
    import dnsle_pkg::*;
#(
    parameter int MAX_LABEL = MAX_LABEL_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  wr_req_t           wr,
    input  cmd_t              head,
    input  logic              empty,
    output logic              pop,
    output rel_t              rel,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_byte,
    output logic              is_length,
    output logic              label_overflow,
    output logic              out_last
);

    localparam int DEPTH = 2 * MAX_LABEL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_READ  = 3'b010,
        B_FETCH = 3'b100
    } back_state_t;

    logic [CHAR_W-1:0] mem [DEPTH];

    back_state_t       state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CHAR_W-1:0] rd_data_reg;

    logic              ov_reg, ov_next;
    logic [CHAR_W-1:0] ob_reg, ob_next;
    logic              ol_reg, ol_next;
    logic              oovf_reg, oovf_next;
    logic              olast_reg, olast_next;

    logic              out_free;
    logic              rd_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    // second bank sits above the first
    assign wr_addr = wr.bank ? AW'(MAX_LABEL) + AW'(wr.idx) : AW'(wr.idx);
    assign rd_addr = bank_reg ? AW'(MAX_LABEL) + AW'(idx_reg) : AW'(idx_reg);
    assign rd_en   = (state_reg == B_READ);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg && !out_ready;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        oovf_next  = oovf_reg;
        olast_next = olast_reg;
        pop        = 1'b0;
        rel        = '{en: 1'b0, bank: bank_reg};

        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty && out_free)
                begin
                    pop        = 1'b1;
                    ov_next    = 1'b1;
                    ob_next    = CHAR_W'(head.count);
                    ol_next    = 1'b1;
                    oovf_next  = head.ovf;
                    olast_next = (head.count == '0);
                    bank_next  = head.bank;
                    cnt_next   = head.count;
                    idx_next   = '0;
                    if (head.count == '0)
                    begin
                        rel = '{en: 1'b1, bank: head.bank};
                    end
                    else
                    begin
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_FETCH;
            end
            B_FETCH:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ob_next    = rd_data_reg;
                    ol_next    = 1'b0;
                    oovf_next  = 1'b0;
                    olast_next = (idx_reg == cnt_reg - CNT_W'(1));
                    if (idx_reg == cnt_reg - CNT_W'(1))
                    begin
                        rel        = '{en: 1'b1, bank: bank_reg};
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg  <= bank_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        ob_reg    <= ob_next;
        ol_reg    <= ol_next;
        oovf_reg  <= oovf_next;
        olast_reg <= olast_next;
    end

    assign out_valid      = ov_reg;
    assign out_byte       = ob_reg;
    assign is_length      = ol_reg;
    assign label_overflow = oovf_reg;
    assign out_last       = olast_reg;

endmodule

>>> rtl/dns_name_label_encoder_unit.sv
// Top level of the DNS name label encoder: front end, label queue and back end.
//
// Input channel (in_valid/in_ready, in_char, in_last): one character of a dotted
// name per word. A dot, or a word with in_last set, closes the open label.
// Output channel (out_valid/out_ready): one wire byte per word. A closed label
// comes out as its length byte (is_length=1, label_overflow=1 if characters
// past MAX_LABEL were dropped) followed by its characters; out_last marks the
// final word of the label. A name ending in a dot sends no empty label after it.
// Root terminator is not sent.
// Characters are written into one of two label banks, one word per cycle while
// in_ready is high. A closed label enters a two-entry queue; the back end reads
// the bank through a registered memory port, so each character word passes the
// B_READ and B_FETCH states, while the length byte goes from the queue head
// straight to the output register.
// The front keeps filling the other bank meanwhile; in_ready drops only when
// both banks hold labels not yet sent. A stalled receiver holds the output
// register and backs up through the queue to in_ready. Reset empties the queue,
// frees both banks and clears the open label; no clearing pass is needed.
module dns_name_label_encoder_unit
    import dnsle_pkg::*;
#(
    parameter int MAX_LABEL = MAX_LABEL_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_byte,
    output logic              is_length,
    output logic              label_overflow,
    output logic              out_last
);

    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    cmd_t    head;
    logic    empty;
    logic    full;
    wr_req_t wr;
    rel_t    rel;

    // classify characters and fill banks
    dnsle_front #(
        .MAX_LABEL (MAX_LABEL)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_char   (in_char),
        .in_last   (in_last),
        .fifo_full (full),
        .push      (push),
        .push_cmd  (push_cmd),
        .wr        (wr),
        .rel       (rel)
    );

    // closed labels waiting for the back end
    dnsle_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    // label store and output sequencer
    dnsle_back #(
        .MAX_LABEL (MAX_LABEL)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr             (wr),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .rel            (rel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .is_length      (is_length),
        .label_overflow (label_overflow),
        .out_last       (out_last)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the DNS name label encoder: random names in, wire labels checked.
module tb_top;
    import dnsle_pkg::*;

    localparam int ITEMS       = 370;   // least number of input words to offer
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int IDLE_LIMIT  = 2000;  // watchdog: cycles with no word moving
    localparam int DRAIN       = 20;    // quiet cycles after the last expected byte

    // one word on the output channel
    typedef struct packed {
        logic [CHAR_W-1:0] data;
        logic              is_len;
        logic              ovf;
        logic              last;
    } wire_word_t;

    // Predicts the wire bytes of each closed label and matches them against the DUT.
    class label_scoreboard;
        logic [CHAR_W-1:0] label_buf [MAX_LABEL_DEF];
        logic [CNT_W-1:0]  label_len;
        bit                ovf_seen;
        wire_word_t        wire_bytes_q[$];
        int unsigned       errors;
        int unsigned       n_bytes;
        int unsigned       n_labels;
        int unsigned       n_ovf_labels;

        function new();
            label_len = '0;
            ovf_seen  = 1'b0;
        endfunction

        // append one predicted word
        function void queue_word(wire_word_t w);
            wire_bytes_q = {wire_bytes_q, w};
        endfunction

        // length word, then the buffered characters; open label starts over
        function void close_label();
            wire_word_t w;
            int         n;
            n        = int'(label_len);
            w.data   = CHAR_W'(label_len);
            w.is_len = 1'b1;
            w.ovf    = ovf_seen;
            w.last   = (n == 0);
            queue_word(w);
            for (int i = 0; i < n; i++)
            begin
                w.data   = label_buf[i];
                w.is_len = 1'b0;
                w.ovf    = 1'b0;
                w.last   = (i == n - 1);
                queue_word(w);
            end
            n_labels++;
            if (ovf_seen)
                n_ovf_labels++;
            label_len = '0;
            ovf_seen  = 1'b0;
        endfunction

        // accepted input word
        function void note_input(logic [CHAR_W-1:0] c, logic l);
            if (c == DOT_CHAR)
            begin
                close_label();
            end
            else
            begin
                if (label_len < MAX_LABEL_DEF)
                begin
                    label_buf[label_len] = c;
                    label_len++;
                end
                else
                begin
                    ovf_seen = 1'b1;
                end
                if (l)
                    close_label();
            end
        endfunction

        function void cmp_field(string fname, logic [CHAR_W-1:0] e, logic [CHAR_W-1:0] a);
            if (a !== e)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, e, a);
            end
        endfunction

        // accepted output word
        function void check_result(logic [CHAR_W-1:0] b, logic il, logic ov, logic la);
            wire_word_t e;
            if (wire_bytes_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %0h len %b ovf %b last %b",
                         $time, b, il, ov, la);
            end
            else
            begin
                e = wire_bytes_q.pop_front();
                cmp_field("out_byte", e.data, b);
                cmp_field("is_length", CHAR_W'(e.is_len), CHAR_W'(il));
                cmp_field("label_overflow", CHAR_W'(e.ovf), CHAR_W'(ov));
                cmp_field("out_last", CHAR_W'(e.last), CHAR_W'(la));
            end
            n_bytes++;
        endfunction

        function int pending();
            return wire_bytes_q.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [CHAR_W-1:0] in_char = '0;
    logic              in_last = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CHAR_W-1:0] out_byte;
    logic              is_length;
    logic              label_overflow;
    logic              out_last;

    label_scoreboard sb;
    int unsigned     n_sent;
    int unsigned     n_names;
    int unsigned     n_noise;
    int unsigned     burst_left;
    int unsigned     idle_cycles;
    bit              hold_req;
    int unsigned     n_holds;

    dns_name_label_encoder_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_char        (in_char),
        .in_last        (in_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .is_length      (is_length),
        .label_overflow (label_overflow),
        .out_last       (out_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor and watchdog: values read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(in_char, in_last);
            if (out_valid && out_ready)
                sb.check_result(out_byte, is_length, label_overflow, out_last);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("%0t: watchdog, no word moved for %0d cycles, %0d bytes pending",
                         $time, IDLE_LIMIT, sb.pending());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [CHAR_W-1:0] rand_char();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        while (c == DOT_CHAR)
            c = CHAR_W'($urandom_range(0, 255));
        return c;
    endfunction

    // Offer one word and hold it until accepted; bursts end in a random gap.
    task automatic send_word(input logic [CHAR_W-1:0] c, input logic l);
        int unsigned gap;
        in_char  <= c;
        in_last  <= l;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        n_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Well-formed name; force_len >= 0 gives one label of that length.
    task automatic send_name(input int force_len);
        int nl;
        int len;
        bit trail;
        bit fin;
        nl    = (force_len >= 0) ? 1 : $urandom_range(1, 4);
        trail = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < nl; i++)
        begin
            if (force_len >= 0)
                len = force_len;
            else
            begin
                case ($urandom_range(0, 19))
                    0:       len = 0;                      // empty label, dots back to back
                    1:       len = $urandom_range(56, 70); // around the length limit
                    default: len = $urandom_range(1, 8);
                endcase
            end
            fin = (i == nl - 1);
            if (fin && !trail && len == 0)
                len = 1;
            for (int j = 0; j < len; j++)
                send_word(rand_char(), fin && !trail && (j == len - 1));
            if (!fin || trail)
                send_word(DOT_CHAR, fin);
        end
        n_names++;
    endtask

    // Receiver: picks a new ready pattern for each random span; one long hold-off on request.
    initial
    begin : receiver
        int mode;
        int span;
        while (!rst_n) @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            for (int k = 0; k < span; k++)
            begin
                if (hold_req)
                begin
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_req = 1'b0;
                    n_holds++;
                end
                else
                begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        2:       out_ready <= (k % 4 == 0);
                        default: out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        bit hold_done;
        bit pause_done;
        sb         = new();
        hold_done  = 1'b0;
        pause_done = 1'b0;
        burst_left = $urandom_range(1, 40);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone dot gives one zero length word
        send_word(DOT_CHAR, 1'b1);
        // extreme character codes
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        // back-to-back dots give an empty label in the middle
        send_word("a", 1'b0);
        send_word(DOT_CHAR, 1'b0);
        send_word(DOT_CHAR, 1'b0);
        send_word("b", 1'b1);
        // trailing dot: no empty label after it
        send_word("x", 1'b0);
        send_word(DOT_CHAR, 1'b1);
        send_word(DOT_CHAR, 1'b0);
        send_word(DOT_CHAR, 1'b1);
        // single character name
        send_word("q", 1'b1);
        send_word(8'h7F, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(DOT_CHAR, 1'b0);
        send_word(8'h01, 1'b1);

        // labels at, just past and well past the length limit
        send_name(MAX_LABEL_DEF);
        send_name(MAX_LABEL_DEF + 1);
        send_name(MAX_LABEL_DEF + 3);

        while (n_sent < ITEMS)
        begin
            // receiver holds off while names keep coming: banks fill, in_ready drops
            if (!hold_done && n_sent >= 200)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            // sender pause until the block has drained
            if (!pause_done && n_sent >= 300)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0) @(posedge clk);
                repeat (4) @(posedge clk);
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 6) == 0)
            begin
                // noise: any code, dot included, with a random last flag
                send_word(CHAR_W'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
                n_noise++;
            end
            else
            begin
                send_name(-1);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d input words (%0d names, %0d noise words), %0d hold-offs",
                 n_sent, n_names, n_noise, n_holds);
        $display("checked %0d wire bytes in %0d labels, %0d of them over the length limit",
                 sb.n_bytes, sb.n_labels, sb.n_ovf_labels);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/dnsle_pkg.sv
rtl/dnsle_front.sv
rtl/dnsle_cmd_fifo.sv
rtl/dnsle_back.sv
rtl/dns_name_label_encoder_unit.sv
tb/tb_top.sv
